>>> hw/rtl/lfs_pkg.sv
// Shared types and constants of the LED fade sequence PWM driver.
// Used by lfs_fade, lfs_pwm and the top level led_fade_sequence_pwm.
`default_nettype none

package lfs_pkg;

    localparam int CH_COUNT  = 10;
    localparam int LED_COUNT = 8;
    localparam int CH_ROOF   = 8;
    localparam int CH_FLOOR  = 9;
    localparam int DUTY_W    = 8;
    localparam int DIV_W     = 16;
    localparam int PHASE_W   = 5;
    localparam int PHASE_CNT = 18;

    localparam logic [DUTY_W-1:0] DUTY_MAX        = 8'd255;
    localparam logic [DUTY_W-1:0] FLOOR_HOLD      = 8'd150;
    localparam logic [DUTY_W-1:0] ROOF_HOLD       = 8'd130;
    localparam logic [DUTY_W-1:0] ROOF_FAST_LIMIT = 8'd170;
    localparam logic [DUTY_W-1:0] OVERLAP_START   = 8'd100;
    localparam logic [DUTY_W-1:0] LED8_ROOF_START = 8'd125;

    localparam logic [PHASE_W-1:0] PHASE_FIRST   = 5'd1;
    localparam logic [PHASE_W-1:0] PHASE_FADE_IN = 5'd2;
    localparam logic [PHASE_W-1:0] PHASE_LED8_UP = 5'd17;
    localparam logic [PHASE_W-1:0] PHASE_LAST    = 5'd18;

    localparam logic [DIV_W-1:0]    FADE_DIV_RESET = 16'd184;
    localparam logic [CH_COUNT-1:0] PINS_RESET     = 10'b11_0000_0000;

    typedef logic [CH_COUNT-1:0][DUTY_W-1:0] t_duty_vec;

    typedef struct packed {
        logic fire;
        logic start;
        logic tick;
    } t_item_cmd;

    typedef struct packed {
        logic      tick_go;
        t_duty_vec duties;
    } t_fade_view;

endpackage

`default_nettype wire

>>> hw/rtl/lfs_fade.sv
// Fade sequencer: duty levels, phase, hold count, step divider and run flag.
// Depends on lfs_pkg.
`default_nettype none

module lfs_fade (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire lfs_pkg::t_item_cmd       i_cmd,
    input  wire logic [lfs_pkg::DIV_W-1:0] i_fade_divider,
    output lfs_pkg::t_fade_view           o_view,
    output logic                          o_running_next
);
    import lfs_pkg::*;

    t_duty_vec          r_duty, n_duty;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [DUTY_W-1:0]  r_hold, n_hold;
    logic [DIV_W-1:0]   r_step_div, n_step_div;
    logic               r_running, n_running;

    t_duty_vec          duty_pre;
    logic [DUTY_W-1:0]  hold_pre;
    logic [DIV_W-1:0]   sd_pre, sd_inc, div_eff;
    logic               run_pre, start_go, tick_go, step_go, finish, phase_ok;
    logic [PHASE_CNT:1] act;
    logic [PHASE_W-1:0] sel;
    logic [DUTY_W-1:0]  roof_t;

    always_comb begin
        // While idle the phase is always the first one with a zero hold count,
        // so the step taken on a start is the first-phase action.
        start_go = i_cmd.fire & i_cmd.start & ~r_running;
        duty_pre = r_duty;
        hold_pre = r_hold;
        run_pre  = r_running;
        sd_pre   = r_step_div;
        if (start_go) begin
            run_pre  = 1'b1;
            sd_pre   = '0;
            hold_pre = r_hold + DUTY_W'(1);
            if (r_duty[CH_FLOOR] < FLOOR_HOLD) begin
                duty_pre[CH_FLOOR] = r_duty[CH_FLOOR] + DUTY_W'(1);
            end
            if (r_duty[CH_ROOF] < ROOF_HOLD) begin
                duty_pre[CH_ROOF] = r_duty[CH_ROOF] + DUTY_W'(1);
            end
        end

        tick_go = i_cmd.fire & i_cmd.tick & run_pre;
        sd_inc  = sd_pre + DIV_W'(1);
        div_eff = (i_fade_divider == '0) ? DIV_W'(1) : i_fade_divider;
        step_go = tick_go && (sd_inc >= div_eff);

        // A phase whose goal is met is skipped, so the step acts in the first
        // phase at or after the current one that still has work to do.
        act    = '0;
        act[1] = (hold_pre != DUTY_MAX);
        for (int i = 0; i < LED_COUNT; i++) begin
            act[2*i+2] = (duty_pre[i] != '0);
            act[2*i+3] = (duty_pre[i] != DUTY_MAX);
        end
        act[PHASE_CNT] = (duty_pre[CH_FLOOR] != '0);

        sel = '0;
        for (int q = PHASE_CNT; q >= 1; q--) begin
            if (act[q] && (PHASE_W'(q) >= r_phase)) begin
                sel = PHASE_W'(q);
            end
        end
        phase_ok = (r_phase >= PHASE_FIRST) && (r_phase <= PHASE_LAST);
        finish   = !phase_ok || (sel == '0);

        n_duty     = duty_pre;
        n_hold     = hold_pre;
        n_phase    = r_phase;
        n_running  = run_pre;
        n_step_div = step_go ? '0 : (tick_go ? sd_inc : sd_pre);
        roof_t     = duty_pre[CH_ROOF];

        if (step_go) begin
            if (finish) begin
                n_phase   = PHASE_FIRST;
                n_hold    = '0;
                n_running = 1'b0;
            end else begin
                n_phase = sel;
                if (sel == PHASE_FIRST) begin
                    n_hold = hold_pre + DUTY_W'(1);
                    if (duty_pre[CH_FLOOR] < FLOOR_HOLD) begin
                        n_duty[CH_FLOOR] = duty_pre[CH_FLOOR] + DUTY_W'(1);
                    end
                    if (duty_pre[CH_ROOF] < ROOF_HOLD) begin
                        n_duty[CH_ROOF] = duty_pre[CH_ROOF] + DUTY_W'(1);
                    end
                end
                for (int i = 0; i < LED_COUNT; i++) begin
                    if (sel == PHASE_W'(2*i+2)) begin
                        n_duty[i] = duty_pre[i] - DUTY_W'(1);
                    end
                    if (sel == PHASE_W'(2*i+3)) begin
                        n_duty[i] = duty_pre[i] + DUTY_W'(1);
                    end
                    // The next LED starts to light once the rising one passes the overlap level.
                    if (i > 0) begin
                        if ((sel == PHASE_W'(2*i+1)) && (duty_pre[i-1] >= OVERLAP_START)) begin
                            n_duty[i] = duty_pre[i] - DUTY_W'(1);
                        end
                    end
                end
                if (sel == PHASE_FADE_IN) begin
                    if (duty_pre[CH_FLOOR] != DUTY_MAX) begin
                        n_duty[CH_FLOOR] = duty_pre[CH_FLOOR] + DUTY_W'(1);
                    end
                    if (roof_t < ROOF_FAST_LIMIT) begin
                        roof_t = roof_t + DUTY_W'(2);
                    end
                    if ((roof_t >= ROOF_FAST_LIMIT) && (roof_t != DUTY_MAX)) begin
                        roof_t = roof_t + DUTY_W'(1);
                    end
                    n_duty[CH_ROOF] = roof_t;
                end
                if (sel == PHASE_LED8_UP) begin
                    if ((duty_pre[CH_ROOF] > ROOF_HOLD)
                            && (duty_pre[LED_COUNT-1] >= LED8_ROOF_START)) begin
                        n_duty[CH_ROOF] = duty_pre[CH_ROOF] - DUTY_W'(1);
                    end
                end
                if (sel == PHASE_LAST) begin
                    n_duty[CH_FLOOR] = duty_pre[CH_FLOOR] - DUTY_W'(1);
                    if (duty_pre[CH_ROOF] != '0) begin
                        n_duty[CH_ROOF] = duty_pre[CH_ROOF] - DUTY_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LED_COUNT; i++) begin
                r_duty[i] <= DUTY_MAX;
            end
            r_duty[CH_ROOF]  <= '0;
            r_duty[CH_FLOOR] <= '0;
            r_phase          <= PHASE_FIRST;
            r_hold           <= '0;
            r_step_div       <= '0;
            r_running        <= 1'b0;
        end else begin
            r_duty     <= n_duty;
            r_phase    <= n_phase;
            r_hold     <= n_hold;
            r_step_div <= n_step_div;
            r_running  <= n_running;
        end
    end

    assign o_view.tick_go  = tick_go;
    assign o_view.duties   = duty_pre;
    assign o_running_next  = n_running;

endmodule

`default_nettype wire

>>> hw/rtl/lfs_pwm.sv
// PWM generator: tick-driven count, latched duties and the pin image.
// Depends on lfs_pkg.
`default_nettype none

module lfs_pwm (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire lfs_pkg::t_fade_view           i_view,
    output logic [lfs_pkg::CH_COUNT-1:0]       o_pins_next
);
    import lfs_pkg::*;

    logic [DUTY_W-1:0]   r_count, n_count;
    t_duty_vec           r_latched, n_latched;
    logic [CH_COUNT-1:0] r_pins, n_pins;

    always_comb begin
        n_count   = r_count;
        n_latched = r_latched;
        n_pins    = r_pins;
        if (i_view.tick_go) begin
            n_count = r_count + DUTY_W'(1);
            // On wrap the duties are sampled and every pin is cleared before the compare below.
            if (n_count == '0) begin
                n_latched = i_view.duties;
                n_pins    = '0;
            end
            for (int i = 0; i < CH_COUNT; i++) begin
                if ((n_latched[i] == n_count) && (n_latched[i] != DUTY_MAX)) begin
                    n_pins[i] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_latched <= '0;
            r_pins    <= PINS_RESET;
        end else begin
            r_count   <= n_count;
            r_latched <= n_latched;
            r_pins    <= n_pins;
        end
    end

    assign o_pins_next = n_pins;

endmodule

`default_nettype wire

>>> hw/rtl/led_fade_sequence_pwm.sv
// Top level of the ten-channel PWM lamp driver with its fade sequence.
// Depends on lfs_pkg, lfs_fade and lfs_pwm.
//
//   Port group   Direction  Handshake                  Content
//   input word   in         i_in_valid / o_in_ready    i_tick, i_start_request
//   result word  out        o_out_valid / i_out_ready  o_led_pins, o_roof_pin, o_floor_pin,
//                                                      o_busy_res
//   fade divider in         i_cfg_we                   i_cfg_wdata
//
// Each word is held in an input register, passes through the combinational logic of the
// sequencer and the PWM counter, and lands in the result register, one new word per cycle
// while the result side does not stall. While a result waits, the input register still takes
// one word. Reset is synchronous, active low, and leaves the block idle with the floor and
// roof pins of the PWM pin image high; the result register itself is not reset.
`default_nettype none

module led_fade_sequence_pwm (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic                      i_tick,
    input  wire logic                      i_start_request,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic [7:0]                     o_led_pins,
    output logic                           o_roof_pin,
    output logic                           o_floor_pin,
    output logic                           o_busy_res,
    input  wire logic                      i_cfg_we,
    input  wire logic [lfs_pkg::DIV_W-1:0] i_cfg_wdata
);
    import lfs_pkg::*;

    logic                r_in_valid;
    logic                r_in_tick;
    logic                r_in_start;
    logic                r_out_valid;
    logic [CH_COUNT-1:0] r_out_pins;
    logic                r_out_busy;
    logic [DIV_W-1:0]    r_fade_div;

    logic                fire;
    logic                in_accept;
    t_item_cmd           cmd;
    t_fade_view          view;
    logic                running_next;
    logic [CH_COUNT-1:0] pins_next;

    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;
    assign in_accept  = i_in_valid && o_in_ready;

    assign cmd.fire  = fire;
    assign cmd.start = r_in_start;
    assign cmd.tick  = r_in_tick;

    lfs_fade u_fade (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_fade_divider (r_fade_div),
        .o_view         (view),
        .o_running_next (running_next)
    );

    lfs_pwm u_pwm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_view      (view),
        .o_pins_next (pins_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fade_div  <= FADE_DIV_RESET;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_fade_div <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_tick  <= i_tick;
            r_in_start <= i_start_request;
        end
        if (fire) begin
            r_out_pins <= pins_next;
            r_out_busy <= running_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_led_pins  = r_out_pins[LED_COUNT-1:0];
    assign o_roof_pin  = r_out_pins[CH_ROOF];
    assign o_floor_pin = r_out_pins[CH_FLOOR];
    assign o_busy_res  = r_out_busy;

endmodule

`default_nettype wire

>>> sim/lamp_scoreboard_pkg.sv
// Scoreboard for the LED fade sequence PWM driver: a cycle-free model of the
// fade choreography and PWM counter, plus the queue of expected result words.
// Depends on lfs_pkg for widths, duty limits and phase codes.
package lamp_scoreboard_pkg;

    import lfs_pkg::*;

    typedef struct packed {
        logic [LED_COUNT-1:0] led;
        logic                 roof;
        logic                 floor;
        logic                 busy;
    } t_lamp_word;

    class lamp_scoreboard;

        logic [DUTY_W-1:0]   duty [CH_COUNT];
        logic [DUTY_W-1:0]   latched [CH_COUNT];
        logic [DUTY_W-1:0]   pwm_count;
        logic [DUTY_W-1:0]   hold_count;
        logic [PHASE_W-1:0]  phase;
        logic [DIV_W-1:0]    step_count;
        logic [DIV_W-1:0]    divider;
        logic [CH_COUNT-1:0] pins;
        bit                  running;
        t_lamp_word          want_q[$];
        int                  failures;
        int                  sequences_done;

        function new();
            for (int i = 0; i < CH_COUNT; i++) begin
                duty[i]    = (i < LED_COUNT) ? DUTY_MAX : '0;
                latched[i] = '0;
            end
            pwm_count      = '0;
            hold_count     = '0;
            phase          = PHASE_FIRST;
            step_count     = '0;
            divider        = FADE_DIV_RESET;
            pins           = PINS_RESET;
            running        = 1'b0;
            failures       = 0;
            sequences_done = 0;
        endfunction

        function void set_divider(logic [DIV_W-1:0] value);
            divider = value;
        endfunction

        function int pending();
            return want_q.size();
        endfunction

        function void end_sequence();
            phase          = PHASE_FIRST;
            hold_count     = '0;
            running        = 1'b0;
            sequences_done++;
        endfunction

        // One fade step. A phase whose goal is already met falls through to the
        // next phase, so each call makes exactly one step or ends the sequence.
        function void advance_fade();
            logic [PHASE_W-1:0] p;
            int                 k;
            for (int guard = 0; guard < 24; guard++) begin
                p = phase;
                if (p == PHASE_FIRST) begin
                    if (hold_count < DUTY_MAX) begin
                        if (duty[CH_FLOOR] < FLOOR_HOLD) duty[CH_FLOOR]++;
                        if (duty[CH_ROOF] < ROOF_HOLD) duty[CH_ROOF]++;
                        hold_count++;
                        return;
                    end
                    phase = PHASE_FADE_IN;
                end else if (p >= PHASE_FADE_IN && p < PHASE_LED8_UP && !p[0]) begin
                    k = p / 2 - 1;
                    if (duty[k] > 0) begin
                        duty[k]--;
                        if (p == PHASE_FADE_IN) begin
                            if (duty[CH_FLOOR] < DUTY_MAX) duty[CH_FLOOR]++;
                            if (duty[CH_ROOF] < ROOF_FAST_LIMIT) duty[CH_ROOF] += 2;
                            if (duty[CH_ROOF] >= ROOF_FAST_LIMIT && duty[CH_ROOF] < DUTY_MAX)
                                duty[CH_ROOF]++;
                        end
                        return;
                    end
                    phase = p + 1'b1;
                end else if (p > PHASE_FADE_IN && p <= PHASE_LED8_UP) begin
                    k = (p - 1) / 2 - 1;
                    if (duty[k] < DUTY_MAX) begin
                        duty[k]++;
                        if (p < PHASE_LED8_UP) begin
                            // The next LED starts to light once this one passes the overlap mark.
                            if (duty[k] > OVERLAP_START) duty[k+1]--;
                        end else if (duty[CH_ROOF] > ROOF_HOLD &&
                                     duty[LED_COUNT-1] > LED8_ROOF_START) begin
                            duty[CH_ROOF]--;
                        end
                        return;
                    end
                    phase = p + 1'b1;
                end else if (p == PHASE_LAST) begin
                    if (duty[CH_FLOOR] > 0) begin
                        duty[CH_FLOOR]--;
                        if (duty[CH_ROOF] > 0) duty[CH_ROOF]--;
                        return;
                    end
                    end_sequence();
                    return;
                end else begin
                    end_sequence();
                    return;
                end
            end
            end_sequence();
        endfunction

        function void note_word(logic tick, logic start);
            logic [DIV_W-1:0] div;
            if (start && !running) begin
                running    = 1'b1;
                step_count = '0;
                advance_fade();
            end
            if (tick && running) begin
                div = (divider == 0) ? DIV_W'(1) : divider;
                pwm_count++;
                if (pwm_count == 0) begin
                    latched = duty;
                    pins    = '0;
                end
                // A latched duty at full scale never sets its pin.
                for (int i = 0; i < CH_COUNT; i++) begin
                    if (latched[i] == pwm_count && latched[i] != DUTY_MAX) pins[i] = 1'b1;
                end
                step_count++;
                if (step_count >= div) begin
                    step_count = '0;
                    advance_fade();
                end
            end
            want_q.push_back('{led: pins[LED_COUNT-1:0], roof: pins[CH_ROOF],
                               floor: pins[CH_FLOOR], busy: running});
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= 10) $display("%s", msg);
        endfunction

        function void check_word(t_lamp_word got);
            t_lamp_word want;
            if (want_q.size() == 0) begin
                flag($sformatf("unexpected result word: led=%02h roof=%0d floor=%0d busy=%0d",
                               got.led, got.roof, got.floor, got.busy));
                return;
            end
            want = want_q.pop_front();
            if (got !== want) begin
                flag($sformatf({"result word mismatch: expected led=%02h roof=%0d floor=%0d ",
                                "busy=%0d, got led=%02h roof=%0d floor=%0d busy=%0d"},
                               want.led, want.roof, want.floor, want.busy,
                               got.led, got.roof, got.floor, got.busy));
            end
        endfunction

    endclass

endpackage

>>> sim/testbench.sv
// Testbench for led_fade_sequence_pwm: drives tick/start words and divider writes,
// checks every result word against lamp_scoreboard.
// Depends on lfs_pkg, lamp_scoreboard_pkg and the RTL of the block.
module testbench;

    import lfs_pkg::*;
    import lamp_scoreboard_pkg::*;

    localparam int QUIET_LIMIT = 400;

    logic             i_clk     = 1'b0;
    logic             i_rst_n   = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_tick   = 1'b0;
    logic             in_start  = 1'b0;
    logic             out_ready = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [DIV_W-1:0] cfg_wdata = '0;

    logic             in_ready;
    logic             out_valid;
    logic [7:0]       led_pins;
    logic             roof_pin;
    logic             floor_pin;
    logic             busy_res;
    t_lamp_word       seen_word;

    bit               burst_in  = 1'b0;
    bit               burst_out = 1'b0;
    int               quiet_cycles = 0;

    lamp_scoreboard   sb = new();

    always #6 i_clk = ~i_clk;

    led_fade_sequence_pwm u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_tick          (in_tick),
        .i_start_request (in_start),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_led_pins      (led_pins),
        .o_roof_pin      (roof_pin),
        .o_floor_pin     (floor_pin),
        .o_busy_res      (busy_res),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata)
    );

    assign seen_word = {led_pins, roof_pin, floor_pin, busy_res};

    // A result accepted at an edge always belongs to a word accepted earlier,
    // so it is checked before the word of the same edge is noted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_valid && out_ready) sb.check_word(seen_word);
            if (in_valid && in_ready) sb.note_word(in_tick, in_start);
            if ((out_valid && out_ready) || (in_valid && in_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send_word(input logic tick, input logic start);
        int gap;
        gap = burst_in ? 0 : $urandom_range(19, 0);
        if ($urandom_range(39, 0) == 0) burst_in = !burst_in;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_tick  <= tick;
        in_start <= start;
        in_valid <= 1'b1;
        do @(posedge i_clk); while (!in_ready);
    endtask

    // Called at the edge that accepted the last word; waits until the block is drained.
    task automatic write_divider(input logic [DIV_W-1:0] value);
        in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        sb.set_divider(value);
    endtask

    // Mostly a steady tick stream with rare start presses; one word in eight is noise.
    task automatic run_random(input int count, input int until_done);
        logic tick;
        logic start;
        for (int n = 0; n < count || (sb.sequences_done < until_done && n < 9000); n++) begin
            if ($urandom_range(7, 0) == 0) begin
                tick  = 1'($urandom_range(1, 0));
                start = 1'($urandom_range(1, 0));
            end else begin
                tick  = 1'b1;
                start = ($urandom_range(15, 0) == 0);
            end
            send_word(tick, start);
        end
    endtask

    initial begin
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = burst_out ? 0 : $urandom_range(19, 0);
            if ($urandom_range(39, 0) == 0) burst_out = !burst_out;
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!out_valid);
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Idle word, tick while idle, start without tick, start while running.
        send_word(1'b0, 1'b0);
        send_word(1'b1, 1'b0);
        send_word(1'b0, 1'b1);
        send_word(1'b0, 1'b1);
        send_word(1'b1, 1'b1);
        repeat (4) send_word(1'b1, 1'b0);

        // A zero divider steps on every tick.
        write_divider('0);
        repeat (6) send_word(1'b1, 1'b0);
        send_word(1'b0, 1'b0);
        send_word(1'b1, 1'b1);

        write_divider(16'hFFFF);
        repeat (3) send_word(1'b1, 1'b0);

        // Fastest stepping carries the choreography through its first phases.
        write_divider(16'd1);
        run_random(600, 0);
        write_divider('0);
        run_random(200, 0);
        write_divider(16'd2);
        run_random(100, 0);
        write_divider(16'hFFFF);
        run_random(40, 0);
        write_divider(DIV_W'($urandom_range(400, 3)));
        run_random(60, 0);
        write_divider(FADE_DIV_RESET);
        run_random(40, 0);
        write_divider(DIV_W'($urandom_range(65535, 1)));
        run_random(40, 0);

        in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (8) @(posedge i_clk);
        if (sb.failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
